[src/pnt_pkg.sv]
// ----------------------------------------------------------------------------
// pnt_pkg
// shared constants for the perfect number test block
// ----------------------------------------------------------------------------
`default_nettype none

package pnt_pkg;

  localparam int NUMBER_BITS  = 31;
  localparam int FIRST_FACTOR = 2;
  localparam int SUM_INIT     = 1;

endpackage

`default_nettype wire

[src/perfect_number_test_top.sv]
// ----------------------------------------------------------------------------
// perfect_number_test_top
// decides whether a number is perfect by trial division and divisor summing
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on the rising edge where start is high and busy is low;
//   in_number is sampled there and masked to VALUE_BITS bits.
//   the result is shown on out_tested_number / out_is_perfect for exactly one
//   cycle, marked by out_valid; the receiver cannot stall the block.
// timing:
//   each trial factor f = 2, 3, ... runs a restoring division, one quotient
//   bit per cycle through the dividend shift register, then a check; when f
//   divides the number, f and then, if it differs from f, the quotient are
//   added to the divisor sum, each add followed by a test against n. the
//   search ends when the quotient falls below f, or early when the divisor
//   sum passes n; values below 2 are answered from idle. busy is high from
//   accept until the result strobe. one request is processed at a time.
// reset:
//   rst_n low returns the controller to idle and clears out_valid; no
//   request in flight survives reset.
// ----------------------------------------------------------------------------
`default_nettype none

module perfect_number_test_top
  import pnt_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [NUMBER_BITS-1:0] in_number,
  output logic                        out_valid,
  output logic [NUMBER_BITS-1:0]      out_tested_number,
  output logic                        out_is_perfect
);

  localparam int W  = VALUE_BITS;
  localparam int FW = (W + 1) / 2 + 1;
  localparam int SW = W + 1;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CHECK, S_ADD_F, S_TEST_F, S_ADD_Q, S_TEST_Q
  } state_t;

  state_t               state_r;
  logic [W-1:0]         value_r;
  logic [W-1:0]         dividend_r;
  logic [W-1:0]         quot_r;
  logic [FW-1:0]        rem_r;
  logic [FW-1:0]        factor_r;
  logic [SW-1:0]        sum_r;
  logic [CW-1:0]        cnt_r;
  logic                 out_valid_r;
  logic                 out_perfect_r;
  logic [NUMBER_BITS-1:0] out_tested_r;

  logic [W-1:0]           in_value;
  logic [NUMBER_BITS-1:0] in_tested;
  logic [FW:0]            trial;
  logic                   fits;
  logic [FW-1:0]          rem_nxt;
  logic [W-1:0]           factor_ext;
  logic                   sum_over;

  generate
    if (W > NUMBER_BITS) begin : g_wide
      assign in_value  = {{(W - NUMBER_BITS){1'b0}}, in_number};
      assign in_tested = in_number;
    end else if (W == NUMBER_BITS) begin : g_equal
      assign in_value  = in_number;
      assign in_tested = in_number;
    end else begin : g_narrow
      assign in_value  = in_number[W-1:0];
      assign in_tested = {{(NUMBER_BITS - W){1'b0}}, in_number[W-1:0]};
    end
  endgenerate

  assign trial      = {rem_r, dividend_r[W-1]};
  assign fits       = trial >= {1'b0, factor_r};
  assign rem_nxt    = fits ? FW'(trial - {1'b0, factor_r}) : trial[FW-1:0];
  assign factor_ext = {{(W - FW){1'b0}}, factor_r};
  assign sum_over   = sum_r > {1'b0, value_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            value_r      <= in_value;
            out_tested_r <= in_tested;
            sum_r        <= SW'(SUM_INIT);
            factor_r     <= FW'(FIRST_FACTOR);
            dividend_r   <= in_value;
            quot_r       <= '0;
            rem_r        <= '0;
            cnt_r        <= CW'(W);
            if (in_value < W'(FIRST_FACTOR)) begin
              out_valid_r   <= 1'b1;
              out_perfect_r <= 1'b0;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r      <= rem_nxt;
          quot_r     <= {quot_r[W-2:0], fits};
          dividend_r <= {dividend_r[W-2:0], 1'b0};
          cnt_r      <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (quot_r < factor_ext) begin
            out_valid_r   <= 1'b1;
            out_perfect_r <= sum_r == {1'b0, value_r};
            state_r       <= S_IDLE;
          end else if (rem_r == '0) begin
            state_r <= S_ADD_F;
          end else begin
            factor_r   <= factor_r + FW'(1);
            dividend_r <= value_r;
            quot_r     <= '0;
            rem_r      <= '0;
            cnt_r      <= CW'(W);
            state_r    <= S_DIV;
          end
        end
        S_ADD_F: begin
          sum_r   <= sum_r + {{(SW - FW){1'b0}}, factor_r};
          state_r <= S_TEST_F;
        end
        S_TEST_F: begin
          if (sum_over) begin
            out_valid_r   <= 1'b1;
            out_perfect_r <= 1'b0;
            state_r       <= S_IDLE;
          end else if (quot_r != factor_ext) begin
            state_r <= S_ADD_Q;
          end else begin
            factor_r   <= factor_r + FW'(1);
            dividend_r <= value_r;
            quot_r     <= '0;
            rem_r      <= '0;
            cnt_r      <= CW'(W);
            state_r    <= S_DIV;
          end
        end
        S_ADD_Q: begin
          sum_r   <= sum_r + {1'b0, quot_r};
          state_r <= S_TEST_Q;
        end
        S_TEST_Q: begin
          if (sum_over) begin
            out_valid_r   <= 1'b1;
            out_perfect_r <= 1'b0;
            state_r       <= S_IDLE;
          end else begin
            factor_r   <= factor_r + FW'(1);
            dividend_r <= value_r;
            quot_r     <= '0;
            rem_r      <= '0;
            cnt_r      <= CW'(W);
            state_r    <= S_DIV;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_tested_number = out_tested_r;
  assign out_is_perfect    = out_perfect_r;

endmodule

`default_nettype wire
